>>> sv/ptc_pkg.sv
// Shared types and constants for the pixel tissue class and edge statistics block.
// No dependencies; used by every module of the block and by its checker.
package ptc_pkg;

    localparam int PixW     = 8;
    localparam int SizeW    = 11;
    localparam int IdxW     = 10;
    localparam int CntW     = 21;
    localparam int ClassW   = 2;
    localparam int FlagW    = 6;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 11;

    localparam int MaxRowsDef = 1024;
    localparam int MaxColsDef = 1024;

    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

    // register reset values
    localparam logic [PixW-1:0]  DarkLimitRst      = 8'd85;
    localparam logic [PixW-1:0]  GreyLimitRst      = 8'd170;
    localparam logic [PixW-1:0]  EdgeThresholdRst  = 8'd80;
    localparam logic [PixW-1:0]  VeryDarkLimitRst  = 8'd20;
    localparam logic [PixW-1:0]  VeryBrightLimitRst = 8'd240;
    localparam logic [SizeW-1:0] FrameRowsRst      = 11'd4;
    localparam logic [SizeW-1:0] FrameColsRst      = 11'd4;

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DARK_LIMIT        = 3'd0,
        CFG_GREY_LIMIT        = 3'd1,
        CFG_EDGE_THRESHOLD    = 3'd2,
        CFG_VERY_DARK_LIMIT   = 3'd3,
        CFG_VERY_BRIGHT_LIMIT = 3'd4,
        CFG_FRAME_ROWS        = 3'd5,
        CFG_FRAME_COLS        = 3'd6
    } t_cfg_idx;

    // tissue class codes
    localparam logic [ClassW-1:0] ClassDark   = 2'd0;
    localparam logic [ClassW-1:0] ClassGrey   = 2'd1;
    localparam logic [ClassW-1:0] ClassBright = 2'd2;

    // observation flag bit positions
    localparam int FlagBrightHalf   = 0;
    localparam int FlagDarkTwoFifth = 1;
    localparam int FlagGreyThreeFifth = 2;
    localparam int FlagAllPresent   = 3;
    localparam int FlagVeryDark     = 4;
    localparam int FlagVeryBright   = 5;

    typedef struct packed {
        logic [PixW-1:0]  dark_limit;
        logic [PixW-1:0]  grey_limit;
        logic [PixW-1:0]  edge_threshold;
        logic [PixW-1:0]  very_dark_limit;
        logic [PixW-1:0]  very_bright_limit;
        logic [SizeW-1:0] frame_rows;
        logic [SizeW-1:0] frame_cols;
    } t_cfg;

    typedef struct packed {
        logic [ClassW-1:0] tissue_class;
        logic              is_edge;
        logic              edge_rising;
        logic [PixW-1:0]   diff;
        logic              very_dark;
        logic              very_bright;
    } t_pix_eval;

    typedef struct packed {
        logic [IdxW-1:0]  row_index;
        logic [IdxW-1:0]  col_index;
        logic             frame_done;
        logic [CntW-1:0]  dark_total;
        logic [CntW-1:0]  grey_total;
        logic [CntW-1:0]  bright_total;
        logic [FlagW-1:0] flags;
    } t_frame_res;

endpackage

>>> sv/ptc_pixel_eval.sv
// Per-pixel class and left-neighbour edge evaluation (combinational).
// Depends on ptc_pkg for the configuration and result structs.
module ptc_pixel_eval (
    input  logic [ptc_pkg::PixW-1:0] i_pix,
    input  logic [ptc_pkg::PixW-1:0] i_left_pixel,
    input  logic                     i_first_col,
    input  ptc_pkg::t_cfg            i_cfg,
    output ptc_pkg::t_pix_eval       o_eval
);

    logic [ptc_pkg::PixW-1:0]   abs_diff;
    logic                       brighter;
    logic [ptc_pkg::ClassW-1:0] pix_class;

    // class from the two limits, first match wins
    always_comb begin
        priority if (i_pix <= i_cfg.dark_limit) begin
            pix_class = ptc_pkg::ClassDark;
        end else if (i_pix <= i_cfg.grey_limit) begin
            pix_class = ptc_pkg::ClassGrey;
        end else begin
            pix_class = ptc_pkg::ClassBright;
        end
    end

    // absolute difference and direction against the left neighbour
    assign brighter = i_pix > i_left_pixel;
    assign abs_diff = brighter ? (i_pix - i_left_pixel) : (i_left_pixel - i_pix);

    assign o_eval.tissue_class = pix_class;
    assign o_eval.diff         = i_first_col ? '0 : abs_diff;
    assign o_eval.is_edge      = !i_first_col && (abs_diff > i_cfg.edge_threshold);
    assign o_eval.edge_rising  = o_eval.is_edge && brighter;
    assign o_eval.very_dark    = i_pix < i_cfg.very_dark_limit;
    assign o_eval.very_bright  = i_pix > i_cfg.very_bright_limit;

endmodule

>>> sv/ptc_frame_stats.sv
// Raster position, left pixel, class counters and end-of-frame observation flags.
// Depends on ptc_pkg; advanced once per pixel word by the top level.
module ptc_frame_stats #(
    parameter int MAX_ROWS = ptc_pkg::MaxRowsDef,
    parameter int MAX_COLS = ptc_pkg::MaxColsDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [ptc_pkg::PixW-1:0]  i_pix,
    input  ptc_pkg::t_pix_eval        i_eval,
    input  logic [ptc_pkg::SizeW-1:0] i_frame_rows,
    input  logic [ptc_pkg::SizeW-1:0] i_frame_cols,
    output logic [ptc_pkg::PixW-1:0]  o_left_pixel,
    output logic                      o_first_col,
    output ptc_pkg::t_frame_res       o_res
);

    localparam int RowW  = $clog2(MAX_ROWS + 1);
    localparam int ColW  = $clog2(MAX_COLS + 1);
    localparam int RowCW = (RowW > ptc_pkg::SizeW) ? RowW : ptc_pkg::SizeW;
    localparam int ColCW = (ColW > ptc_pkg::SizeW) ? ColW : ptc_pkg::SizeW;
    localparam int CntW  = ptc_pkg::CntW;
    localparam int SumW  = CntW + 2;
    localparam int CmpW  = CntW + 5;

    logic [ptc_pkg::PixW-1:0] r_left_pixel;
    logic [RowW-1:0]          r_row, n_row;
    logic [ColW-1:0]          r_col, n_col;
    logic [CntW-1:0]          r_dark, r_grey, r_bright, r_vdark, r_vbright;
    logic [CntW-1:0]          n_dark, n_grey, n_bright, n_vdark, n_vbright;

    logic [RowCW-1:0]   rows_ext;
    logic [ColCW-1:0]   cols_ext;
    logic [RowW-1:0]    rows_eff;
    logic [ColW-1:0]    cols_eff;
    logic               last_row, last_col, done;
    logic [SumW-1:0]    total;
    logic [CmpW-1:0]    t_c, d_c, g_c, b_c, vd_c, vb_c;
    logic [RowW+ptc_pkg::IdxW-1:0] row_wide;
    logic [ColW+ptc_pkg::IdxW-1:0] col_wide;

    // clamp the configured frame size into 1 .. maximum
    assign rows_ext = RowCW'(i_frame_rows);
    assign cols_ext = ColCW'(i_frame_cols);
    always_comb begin
        priority if (rows_ext == '0) begin
            rows_eff = RowW'(1);
        end else if (rows_ext > RowCW'(MAX_ROWS)) begin
            rows_eff = RowW'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext[RowW-1:0];
        end
        priority if (cols_ext == '0) begin
            cols_eff = ColW'(1);
        end else if (cols_ext > ColCW'(MAX_COLS)) begin
            cols_eff = ColW'(MAX_COLS);
        end else begin
            cols_eff = cols_ext[ColW-1:0];
        end
    end

    // end of row and end of frame, reached or passed
    assign last_row = ((RowW+1)'(r_row) + (RowW+1)'(1)) >= (RowW+1)'(rows_eff);
    assign last_col = ((ColW+1)'(r_col) + (ColW+1)'(1)) >= (ColW+1)'(cols_eff);
    assign done     = last_row && last_col;

    // saturating counter bumps including this pixel
    always_comb begin
        n_dark    = r_dark;
        n_grey    = r_grey;
        n_bright  = r_bright;
        n_vdark   = r_vdark;
        n_vbright = r_vbright;
        unique case (i_eval.tissue_class)
            ptc_pkg::ClassDark: begin
                if (r_dark != ptc_pkg::CntMax) n_dark = r_dark + 1'b1;
            end
            ptc_pkg::ClassGrey: begin
                if (r_grey != ptc_pkg::CntMax) n_grey = r_grey + 1'b1;
            end
            default: begin
                if (r_bright != ptc_pkg::CntMax) n_bright = r_bright + 1'b1;
            end
        endcase
        if (i_eval.very_dark && (r_vdark != ptc_pkg::CntMax)) n_vdark = r_vdark + 1'b1;
        if (i_eval.very_bright && (r_vbright != ptc_pkg::CntMax)) n_vbright = r_vbright + 1'b1;
    end

    // next raster position, wrap at end of row and frame
    always_comb begin
        priority if (done) begin
            n_row = '0;
            n_col = '0;
        end else if (last_col) begin
            n_row = r_row + 1'b1;
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + 1'b1;
        end
    end

    // fraction compares on the frame totals, scaled by small constants
    assign total = SumW'(n_dark) + SumW'(n_grey) + SumW'(n_bright);
    assign t_c   = CmpW'(total);
    assign d_c   = CmpW'(n_dark);
    assign g_c   = CmpW'(n_grey);
    assign b_c   = CmpW'(n_bright);
    assign vd_c  = CmpW'(n_vdark);
    assign vb_c  = CmpW'(n_vbright);

    always_comb begin
        o_res.flags = '0;
        if (done) begin
            o_res.flags[ptc_pkg::FlagBrightHalf] = (b_c << 1) > t_c;
            o_res.flags[ptc_pkg::FlagDarkTwoFifth] =
                !((b_c << 1) > t_c) && (((d_c << 2) + d_c) > (t_c << 1));
            o_res.flags[ptc_pkg::FlagGreyThreeFifth] = ((g_c << 2) + g_c) > ((t_c << 1) + t_c);
            o_res.flags[ptc_pkg::FlagAllPresent] =
                (n_dark != '0) && (n_grey != '0) && (n_bright != '0);
            o_res.flags[ptc_pkg::FlagVeryDark] = ((vd_c << 3) + (vd_c << 1)) > ((t_c << 1) + t_c);
            o_res.flags[ptc_pkg::FlagVeryBright] =
                ((vb_c << 3) + (vb_c << 1)) > ((t_c << 1) + t_c);
        end
    end

    // low index bits of the position
    assign row_wide = {{ptc_pkg::IdxW{1'b0}}, r_row};
    assign col_wide = {{ptc_pkg::IdxW{1'b0}}, r_col};

    assign o_res.row_index    = row_wide[ptc_pkg::IdxW-1:0];
    assign o_res.col_index    = col_wide[ptc_pkg::IdxW-1:0];
    assign o_res.frame_done   = done;
    assign o_res.dark_total   = n_dark;
    assign o_res.grey_total   = n_grey;
    assign o_res.bright_total = n_bright;

    assign o_left_pixel = r_left_pixel;
    assign o_first_col  = (r_col == '0);

    // advance position and counters once per pixel, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_pixel <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_dark       <= '0;
            r_grey       <= '0;
            r_bright     <= '0;
            r_vdark      <= '0;
            r_vbright    <= '0;
        end else if (i_step) begin
            r_left_pixel <= i_pix;
            r_row        <= n_row;
            r_col        <= n_col;
            if (done) begin
                r_dark    <= '0;
                r_grey    <= '0;
                r_bright  <= '0;
                r_vdark   <= '0;
                r_vbright <= '0;
            end else begin
                r_dark    <= n_dark;
                r_grey    <= n_grey;
                r_bright  <= n_bright;
                r_vdark   <= n_vdark;
                r_vbright <= n_vbright;
            end
        end
    end

endmodule

>>> sv/pixel_tissue_class_and_edge_stats.sv
// Top level: pixel tissue classifier with left-neighbour edge and frame statistics.
// Depends on ptc_pkg, ptc_pixel_eval and ptc_frame_stats.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-------------------------------
//  pixel in  | in        | i_valid / o_stall       | i_intensity
//  result    | out       | o_valid / i_stall       | class, edge, indices, totals, flags
//  config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One pixel word per cycle while i_stall is low; each word passes the input register, then
// the result register after one pass of compare and counter logic.
// Synchronous active-low reset restores the register defaults and clears the
// raster position, left pixel and all counters.
// o_stall rises only when both the input and result registers are full and
// i_stall is high; configuration writes are taken in every cycle.
module pixel_tissue_class_and_edge_stats #(
    parameter int MAX_ROWS = ptc_pkg::MaxRowsDef,
    parameter int MAX_COLS = ptc_pkg::MaxColsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel input
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ptc_pkg::PixW-1:0]     i_intensity,
    // result output
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ptc_pkg::ClassW-1:0]   o_tissue_class,
    output logic                         o_is_edge,
    output logic                         o_edge_rising,
    output logic [ptc_pkg::PixW-1:0]     o_neighbour_difference,
    output logic [ptc_pkg::IdxW-1:0]     o_row_index,
    output logic [ptc_pkg::IdxW-1:0]     o_col_index,
    output logic                         o_frame_done,
    output logic [ptc_pkg::CntW-1:0]     o_dark_total,
    output logic [ptc_pkg::CntW-1:0]     o_grey_total,
    output logic [ptc_pkg::CntW-1:0]     o_bright_total,
    output logic [ptc_pkg::FlagW-1:0]    o_observation_flags,
    // configuration write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ptc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [ptc_pkg::CfgDataW-1:0] i_cfg_data
);

    ptc_pkg::t_cfg            r_cfg;
    logic                     r_in_valid;
    logic [ptc_pkg::PixW-1:0] r_in_pix;
    logic                     r_out_valid;
    ptc_pkg::t_pix_eval       r_out_eval;
    ptc_pkg::t_frame_res      r_out_res;

    logic                     out_free, in_free, step;
    logic [ptc_pkg::PixW-1:0] left_pixel;
    logic                     first_col;
    ptc_pkg::t_pix_eval       eval;
    ptc_pkg::t_frame_res      res;

    // handshake: the pipeline moves whenever the result register can take a word
    assign out_free    = !r_out_valid || !i_stall;
    assign in_free     = !r_in_valid || out_free;
    assign step        = r_in_valid && out_free;
    assign o_stall     = !in_free;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_limit        <= ptc_pkg::DarkLimitRst;
            r_cfg.grey_limit        <= ptc_pkg::GreyLimitRst;
            r_cfg.edge_threshold    <= ptc_pkg::EdgeThresholdRst;
            r_cfg.very_dark_limit   <= ptc_pkg::VeryDarkLimitRst;
            r_cfg.very_bright_limit <= ptc_pkg::VeryBrightLimitRst;
            r_cfg.frame_rows        <= ptc_pkg::FrameRowsRst;
            r_cfg.frame_cols        <= ptc_pkg::FrameColsRst;
        end else if (i_cfg_valid) begin
            unique case (ptc_pkg::t_cfg_idx'(i_cfg_index))
                ptc_pkg::CFG_DARK_LIMIT:        r_cfg.dark_limit <= i_cfg_data[7:0];
                ptc_pkg::CFG_GREY_LIMIT:        r_cfg.grey_limit <= i_cfg_data[7:0];
                ptc_pkg::CFG_EDGE_THRESHOLD:    r_cfg.edge_threshold <= i_cfg_data[7:0];
                ptc_pkg::CFG_VERY_DARK_LIMIT:   r_cfg.very_dark_limit <= i_cfg_data[7:0];
                ptc_pkg::CFG_VERY_BRIGHT_LIMIT: r_cfg.very_bright_limit <= i_cfg_data[7:0];
                ptc_pkg::CFG_FRAME_ROWS:        r_cfg.frame_rows <= i_cfg_data;
                ptc_pkg::CFG_FRAME_COLS:        r_cfg.frame_cols <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_pix <= i_intensity;
        end
    end

    ptc_pixel_eval u_eval (
        .i_pix        (r_in_pix),
        .i_left_pixel (left_pixel),
        .i_first_col  (first_col),
        .i_cfg        (r_cfg),
        .o_eval       (eval)
    );

    ptc_frame_stats #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_pix        (r_in_pix),
        .i_eval       (eval),
        .i_frame_rows (r_cfg.frame_rows),
        .i_frame_cols (r_cfg.frame_cols),
        .o_left_pixel (left_pixel),
        .o_first_col  (first_col),
        .o_res        (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_eval <= eval;
            r_out_res  <= res;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_tissue_class         = r_out_eval.tissue_class;
    assign o_is_edge              = r_out_eval.is_edge;
    assign o_edge_rising          = r_out_eval.edge_rising;
    assign o_neighbour_difference = r_out_eval.diff;
    assign o_row_index            = r_out_res.row_index;
    assign o_col_index            = r_out_res.col_index;
    assign o_frame_done           = r_out_res.frame_done;
    assign o_dark_total           = r_out_res.dark_total;
    assign o_grey_total           = r_out_res.grey_total;
    assign o_bright_total         = r_out_res.bright_total;
    assign o_observation_flags    = r_out_res.flags;

    // very-dark/very-bright flags are only needed inside the counters
    logic unused_eval;
    assign unused_eval = r_out_eval.very_dark ^ r_out_eval.very_bright;

endmodule

>>> sv/ptc_checker.sv
// Port-level checks for the pixel tissue classifier, bound to its top level.
// Depends on ptc_pkg for field widths and class codes.
module ptc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [ptc_pkg::ClassW-1:0]   o_tissue_class,
    input logic                         o_is_edge,
    input logic                         o_edge_rising,
    input logic [ptc_pkg::PixW-1:0]     o_neighbour_difference,
    input logic [ptc_pkg::IdxW-1:0]     o_col_index,
    input logic                         o_frame_done,
    input logic [ptc_pkg::CntW-1:0]     o_dark_total,
    input logic [ptc_pkg::FlagW-1:0]    o_observation_flags
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_dark_total)
            && $stable(o_col_index) && $stable(o_observation_flags)))
        else $error("result word changed while stalled");

    // flags only appear on the last pixel of a frame
    a_flags_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |-> (o_observation_flags == '0))
        else $error("observation flags outside frame end");

    // a rising edge is always an edge
    a_rising_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_edge_rising) |-> o_is_edge)
        else $error("rising flag without edge");

    // first column has no left neighbour
    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_col_index == '0)) |-> (!o_is_edge && (o_neighbour_difference == '0)))
        else $error("edge reported in first column");

    // the running dark total includes a dark pixel itself
    a_class_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_tissue_class == ptc_pkg::ClassDark)) |-> (o_dark_total != '0))
        else $error("dark pixel not counted");

endmodule

bind pixel_tissue_class_and_edge_stats ptc_checker u_ptc_checker (.*);

>>> test/pixel_tissue_class_and_edge_stats_test.sv
`timescale 1ns / 1ps
// Self-checking bench for pixel_tissue_class_and_edge_stats: a directed table, a long single row, then random frames.
// Depends on ptc_pkg and the block's RTL; a local predictor works out each result word that the table does not give.
module pixel_tissue_class_and_edge_stats_test;

    typedef struct packed {
        logic [ptc_pkg::ClassW-1:0] tissue_class;
        logic                       is_edge;
        logic                       edge_rising;
        logic [ptc_pkg::PixW-1:0]   diff;
        logic [ptc_pkg::IdxW-1:0]   row_index;
        logic [ptc_pkg::IdxW-1:0]   col_index;
        logic                       frame_done;
        logic [ptc_pkg::CntW-1:0]   dark_total;
        logic [ptc_pkg::CntW-1:0]   grey_total;
        logic [ptc_pkg::CntW-1:0]   bright_total;
        logic [ptc_pkg::FlagW-1:0]  flags;
    } t_pixel_report;

    // one line of the directed table: a register write or a pixel word
    typedef struct packed {
        logic                         kind;
        logic [ptc_pkg::CfgIdxW-1:0]  reg_idx;
        logic [ptc_pkg::CfgDataW-1:0] value;
        logic                         typed;
        t_pixel_report                want;
    } t_script_row;

    typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} t_stall_style;
    typedef enum int {
        PixUniform, PixDark, PixBright, PixGrey, PixBoundary, PixThreshold, PixSmooth
    } t_pixel_style;

    localparam logic                        RowPixel  = 1'b0;
    localparam logic                        RowWrite  = 1'b1;
    localparam logic                        Predicted = 1'b0;
    localparam logic                        Typed     = 1'b1;
    localparam logic [ptc_pkg::CfgIdxW-1:0] CfgSpare  = 3'd7;
    localparam int unsigned                 RandomItems = 690;
    localparam int unsigned                 PrintCap    = 30;
    localparam int                          ScriptLen   = 31;

    // reset frame of 4x4 first, then two short 1x3 frames with odd settings
    localparam t_script_row Script [ScriptLen] = '{
        '{RowPixel, '0, 11'd0, Typed,
          '{ptc_pkg::ClassDark, 1'b0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0,
            21'd1, 21'd0, 21'd0, 6'd0}},
        '{RowPixel, '0, 11'd255, Typed,
          '{ptc_pkg::ClassBright, 1'b1, 1'b1, 8'd255, 10'd0, 10'd1, 1'b0,
            21'd1, 21'd0, 21'd1, 6'd0}},
        '{RowPixel, '0, 11'd85, Typed,
          '{ptc_pkg::ClassDark, 1'b1, 1'b0, 8'd170, 10'd0, 10'd2, 1'b0,
            21'd2, 21'd0, 21'd1, 6'd0}},
        '{RowPixel, '0, 11'd86, Predicted, '0},
        '{RowPixel, '0, 11'd170, Predicted, '0},
        '{RowPixel, '0, 11'd171, Predicted, '0},
        '{RowPixel, '0, 11'd91, Predicted, '0},
        '{RowPixel, '0, 11'd11, Predicted, '0},
        '{RowPixel, '0, 11'd240, Predicted, '0},
        '{RowPixel, '0, 11'd159, Predicted, '0},
        '{RowPixel, '0, 11'd240, Predicted, '0},
        '{RowPixel, '0, 11'd241, Predicted, '0},
        '{RowPixel, '0, 11'd19, Predicted, '0},
        '{RowPixel, '0, 11'd20, Predicted, '0},
        '{RowPixel, '0, 11'd255, Predicted, '0},
        '{RowPixel, '0, 11'd0, Typed,
          '{ptc_pkg::ClassDark, 1'b1, 1'b0, 8'd255, 10'd3, 10'd3, 1'b1,
            21'd6, 21'd4, 21'd6, 6'(1 << ptc_pkg::FlagAllPresent)}},
        '{RowWrite, ptc_pkg::CFG_FRAME_ROWS, 11'd0, Predicted, '0},
        '{RowWrite, ptc_pkg::CFG_FRAME_COLS, 11'd3, Predicted, '0},
        '{RowWrite, ptc_pkg::CFG_DARK_LIMIT, 11'h7FF, Predicted, '0},
        '{RowWrite, ptc_pkg::CFG_VERY_DARK_LIMIT, 11'h0FF, Predicted, '0},
        '{RowWrite, ptc_pkg::CFG_EDGE_THRESHOLD, 11'd0, Predicted, '0},
        '{RowPixel, '0, 11'd7, Predicted, '0},
        '{RowPixel, '0, 11'd200, Predicted, '0},
        '{RowPixel, '0, 11'd255, Predicted, '0},
        '{RowWrite, ptc_pkg::CFG_DARK_LIMIT, 11'd100, Predicted, '0},
        '{RowWrite, ptc_pkg::CFG_GREY_LIMIT, 11'd50, Predicted, '0},
        '{RowWrite, ptc_pkg::CFG_VERY_BRIGHT_LIMIT, 11'd0, Predicted, '0},
        '{RowWrite, CfgSpare, 11'h5A5, Predicted, '0},
        '{RowPixel, '0, 11'd60, Predicted, '0},
        '{RowPixel, '0, 11'd100, Predicted, '0},
        '{RowPixel, '0, 11'd60, Predicted, '0}
    };

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic [ptc_pkg::PixW-1:0]     i_intensity = '0;
    logic                         i_stall     = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic [ptc_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [ptc_pkg::CfgDataW-1:0] i_cfg_data  = '0;

    logic                         o_stall;
    logic                         o_valid;
    logic [ptc_pkg::ClassW-1:0]   o_tissue_class;
    logic                         o_is_edge;
    logic                         o_edge_rising;
    logic [ptc_pkg::PixW-1:0]     o_neighbour_difference;
    logic [ptc_pkg::IdxW-1:0]     o_row_index;
    logic [ptc_pkg::IdxW-1:0]     o_col_index;
    logic                         o_frame_done;
    logic [ptc_pkg::CntW-1:0]     o_dark_total;
    logic [ptc_pkg::CntW-1:0]     o_grey_total;
    logic [ptc_pkg::CntW-1:0]     o_bright_total;
    logic [ptc_pkg::FlagW-1:0]    o_observation_flags;
    logic                         o_cfg_ready;

    // predictor state: shadow registers, raster position and frame counts
    ptc_pkg::t_cfg            cfg_shadow;
    logic [ptc_pkg::PixW-1:0] left_shadow;
    int unsigned   row_at, col_at;
    int unsigned   dark_seen, grey_seen, bright_seen, vdark_seen, vbright_seen;

    t_pixel_report expected_reports [$];
    int unsigned   mismatch_count = 0;
    int unsigned   results_seen   = 0;
    int unsigned   burst_left     = 0;
    int unsigned   stall_age      = 0;
    t_stall_style  stall_style    = StallNone;

    pixel_tissue_class_and_edge_stats dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_intensity            (i_intensity),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_tissue_class         (o_tissue_class),
        .o_is_edge              (o_is_edge),
        .o_edge_rising          (o_edge_rising),
        .o_neighbour_difference (o_neighbour_difference),
        .o_row_index            (o_row_index),
        .o_col_index            (o_col_index),
        .o_frame_done           (o_frame_done),
        .o_dark_total           (o_dark_total),
        .o_grey_total           (o_grey_total),
        .o_bright_total         (o_bright_total),
        .o_observation_flags    (o_observation_flags),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // print one line per mismatch, up to a cap, and count them all
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PrintCap) begin
            $display("[%0t] result %0d: %s", $time, results_seen, what);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 'h%0h, expected 'h%0h", name, got, want));
        end
    endtask

    // size register to effective size: zero acts as one, oversize clips at the maximum
    function automatic int unsigned frame_span(input logic [ptc_pkg::SizeW-1:0] size,
                                               input int unsigned limit);
        if (size == '0) return 1;
        if (size > limit) return limit;
        return 32'(size);
    endfunction

    function automatic int unsigned count_up(input int unsigned c);
        return (c < ptc_pkg::CntMax) ? c + 1 : ptc_pkg::CntMax;
    endfunction

    // classify one accepted pixel, update the frame counts and work out its result word
    function automatic t_pixel_report classify_and_count(input logic [ptc_pkg::PixW-1:0] px);
        t_pixel_report r;
        int unsigned   rows, cols, total, delta;
        logic          last_col, last_row;
        r     = '0;
        rows  = frame_span(cfg_shadow.frame_rows, ptc_pkg::MaxRowsDef);
        cols  = frame_span(cfg_shadow.frame_cols, ptc_pkg::MaxColsDef);
        delta = 0;
        if (px <= cfg_shadow.dark_limit) begin
            r.tissue_class = ptc_pkg::ClassDark;
            dark_seen = count_up(dark_seen);
        end else if (px <= cfg_shadow.grey_limit) begin
            r.tissue_class = ptc_pkg::ClassGrey;
            grey_seen = count_up(grey_seen);
        end else begin
            r.tissue_class = ptc_pkg::ClassBright;
            bright_seen = count_up(bright_seen);
        end
        if (px < cfg_shadow.very_dark_limit) vdark_seen = count_up(vdark_seen);
        if (px > cfg_shadow.very_bright_limit) vbright_seen = count_up(vbright_seen);

        // no neighbour in the first column
        if (col_at > 0) begin
            delta = (px >= left_shadow) ? px - left_shadow : left_shadow - px;
            if (delta > cfg_shadow.edge_threshold) begin
                r.is_edge     = 1'b1;
                r.edge_rising = (px > left_shadow);
            end
        end
        r.diff = delta[ptc_pkg::PixW-1:0];

        last_col = (col_at + 1 >= cols);
        last_row = (row_at + 1 >= rows);
        r.row_index    = row_at[ptc_pkg::IdxW-1:0];
        r.col_index    = col_at[ptc_pkg::IdxW-1:0];
        r.frame_done   = last_col && last_row;
        r.dark_total   = dark_seen[ptc_pkg::CntW-1:0];
        r.grey_total   = grey_seen[ptc_pkg::CntW-1:0];
        r.bright_total = bright_seen[ptc_pkg::CntW-1:0];

        // frame observations as exact fraction compares
        if (r.frame_done) begin
            total = dark_seen + grey_seen + bright_seen;
            if (2 * bright_seen > total) r.flags[ptc_pkg::FlagBrightHalf] = 1'b1;
            else if (5 * dark_seen > 2 * total) r.flags[ptc_pkg::FlagDarkTwoFifth] = 1'b1;
            if (5 * grey_seen > 3 * total) r.flags[ptc_pkg::FlagGreyThreeFifth] = 1'b1;
            if (dark_seen > 0 && grey_seen > 0 && bright_seen > 0) begin
                r.flags[ptc_pkg::FlagAllPresent] = 1'b1;
            end
            if (10 * vdark_seen > 3 * total) r.flags[ptc_pkg::FlagVeryDark] = 1'b1;
            if (10 * vbright_seen > 3 * total) r.flags[ptc_pkg::FlagVeryBright] = 1'b1;
        end

        // advance the raster position, wrapping at row and frame end
        left_shadow = px;
        if (r.frame_done) begin
            row_at = 0;
            col_at = 0;
            dark_seen = 0;
            grey_seen = 0;
            bright_seen = 0;
            vdark_seen = 0;
            vbright_seen = 0;
        end else if (last_col) begin
            col_at = 0;
            row_at++;
        end else begin
            col_at++;
        end
        return r;
    endfunction

    // offer one pixel word, hold it until taken, then perhaps open a gap
    task automatic send_pixel(input logic [ptc_pkg::PixW-1:0] px, input logic use_typed,
                              input t_pixel_report typed_want);
        t_pixel_report predicted;
        int unsigned   gap;
        i_valid     <= 1'b1;
        i_intensity <= px;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (o_stall);
        predicted = classify_and_count(px);
        expected_reports.insert(expected_reports.size(), use_typed ? typed_want : predicted);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hold the write until ready; the caller drops valid afterwards
    task automatic write_reg(input logic [ptc_pkg::CfgIdxW-1:0] idx,
                             input logic [ptc_pkg::CfgDataW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ptc_pkg::CFG_DARK_LIMIT:
                cfg_shadow.dark_limit        = value[ptc_pkg::PixW-1:0];
            ptc_pkg::CFG_GREY_LIMIT:
                cfg_shadow.grey_limit        = value[ptc_pkg::PixW-1:0];
            ptc_pkg::CFG_EDGE_THRESHOLD:
                cfg_shadow.edge_threshold    = value[ptc_pkg::PixW-1:0];
            ptc_pkg::CFG_VERY_DARK_LIMIT:
                cfg_shadow.very_dark_limit   = value[ptc_pkg::PixW-1:0];
            ptc_pkg::CFG_VERY_BRIGHT_LIMIT:
                cfg_shadow.very_bright_limit = value[ptc_pkg::PixW-1:0];
            ptc_pkg::CFG_FRAME_ROWS:
                cfg_shadow.frame_rows        = value;
            ptc_pkg::CFG_FRAME_COLS:
                cfg_shadow.frame_cols        = value;
            default: ;
        endcase
    endtask

    // stop both channels and wait until every result word is back and the pipe is empty
    task automatic drain_results();
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [ptc_pkg::CfgDataW-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 11'd255;
            2:       return ptc_pkg::CfgDataW'($urandom_range(0, 2047));
            default: return ptc_pkg::CfgDataW'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [ptc_pkg::CfgDataW-1:0] pick_size();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return ptc_pkg::CfgDataW'($urandom_range(ptc_pkg::MaxRowsDef + 1, 2047));
            2:       return 11'd1;
            default: return ptc_pkg::CfgDataW'($urandom_range(1, 6));
        endcase
    endfunction

    // pixel content shaped to land on class limits and edge thresholds
    function automatic logic [ptc_pkg::PixW-1:0] pick_pixel(input t_pixel_style style);
        int jump, v;
        v = $urandom_range(0, 255);
        case (style)
            PixDark:   v = $urandom_range(0, cfg_shadow.dark_limit);
            PixBright: v = $urandom_range(cfg_shadow.grey_limit, 255);
            PixGrey:   v = $urandom_range(cfg_shadow.dark_limit, cfg_shadow.grey_limit);
            PixBoundary: begin
                case ($urandom_range(0, 7))
                    0:       v = 0;
                    1:       v = 255;
                    2:       v = cfg_shadow.dark_limit;
                    3:       v = cfg_shadow.dark_limit + 1;
                    4:       v = cfg_shadow.grey_limit;
                    5:       v = cfg_shadow.grey_limit + 1;
                    6:       v = cfg_shadow.very_dark_limit - $urandom_range(0, 1);
                    default: v = cfg_shadow.very_bright_limit + $urandom_range(0, 1);
                endcase
            end
            PixThreshold: begin
                jump = int'(cfg_shadow.edge_threshold) + int'($urandom_range(0, 1));
                v = ($urandom_range(0, 1) == 1) ? int'(left_shadow) + jump
                                                : int'(left_shadow) - jump;
                if (v < 0 || v > 255) v = 2 * int'(left_shadow) - v;
                if (v < 0 || v > 255) v = $urandom_range(0, 255);
            end
            PixSmooth: begin
                v = int'(left_shadow) + int'($urandom_range(0, 16)) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            default: ;
        endcase
        return v[ptc_pkg::PixW-1:0];
    endfunction

    // receiver back-pressure: switch between random stall styles, idle-free stretches included
    always @(posedge i_clk) begin : stall_pattern
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            stall_age++;
            if (stall_age >= 200) begin
                stall_age   = 0;
                stall_style = t_stall_style'($urandom_range(0, 3));
            end
            case (stall_style)
                StallNone:  i_stall <= 1'b0;
                StallLight: i_stall <= ($urandom_range(0, 3) == 0);
                StallHeavy: i_stall <= ($urandom_range(0, 9) < 7);
                default:    i_stall <= ((stall_age % 8) < 3);
            endcase
        end
    end

    // compare each taken result word against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_pixel_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_reports.size() == 0) begin
                report_mismatch("result word with no pixel outstanding");
            end else begin
                want = expected_reports.pop_front();
                compare_field("tissue_class", o_tissue_class, want.tissue_class);
                compare_field("is_edge", o_is_edge, want.is_edge);
                compare_field("edge_rising", o_edge_rising, want.edge_rising);
                compare_field("neighbour_difference", o_neighbour_difference, want.diff);
                compare_field("row_index", o_row_index, want.row_index);
                compare_field("col_index", o_col_index, want.col_index);
                compare_field("frame_done", o_frame_done, want.frame_done);
                compare_field("dark_total", o_dark_total, want.dark_total);
                compare_field("grey_total", o_grey_total, want.grey_total);
                compare_field("bright_total", o_bright_total, want.bright_total);
                compare_field("observation_flags", o_observation_flags, want.flags);
            end
        end
    end

    initial begin : stimulus
        int unsigned  random_sent, span, count;
        t_pixel_style style;

        cfg_shadow = '{ptc_pkg::DarkLimitRst, ptc_pkg::GreyLimitRst,
                       ptc_pkg::EdgeThresholdRst, ptc_pkg::VeryDarkLimitRst,
                       ptc_pkg::VeryBrightLimitRst, ptc_pkg::FrameRowsRst,
                       ptc_pkg::FrameColsRst};
        left_shadow = '0;
        row_at = 0;
        col_at = 0;
        dark_seen = 0;
        grey_seen = 0;
        bright_seen = 0;
        vdark_seen = 0;
        vbright_seen = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < ScriptLen; r++) begin
            if (Script[r].kind == RowWrite) begin
                drain_results();
                write_reg(Script[r].reg_idx, Script[r].value);
            end else begin
                send_pixel(Script[r].value[ptc_pkg::PixW-1:0], Script[r].typed,
                           Script[r].want);
            end
        end

        // long single row at the clipped column count, then shrink it mid-row so the scan wraps
        drain_results();
        write_reg(ptc_pkg::CFG_FRAME_ROWS, 11'd1);
        write_reg(ptc_pkg::CFG_FRAME_COLS, 11'h7FF);
        repeat (40) send_pixel(pick_pixel(PixUniform), Predicted, '0);
        drain_results();
        write_reg(ptc_pkg::CFG_FRAME_COLS, 11'd2);

        // random phases: new settings while idle, then whole frames with shaped content
        random_sent = 0;
        while (random_sent < RandomItems) begin
            drain_results();
            if ($urandom_range(0, 1) == 1) write_reg(ptc_pkg::CFG_DARK_LIMIT, pick_limit());
            if ($urandom_range(0, 1) == 1) write_reg(ptc_pkg::CFG_GREY_LIMIT, pick_limit());
            if ($urandom_range(0, 1) == 1) begin
                write_reg(ptc_pkg::CFG_EDGE_THRESHOLD, pick_limit());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(ptc_pkg::CFG_VERY_DARK_LIMIT, pick_limit());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(ptc_pkg::CFG_VERY_BRIGHT_LIMIT, pick_limit());
            end
            if ($urandom_range(0, 1) == 1) write_reg(ptc_pkg::CFG_FRAME_ROWS, pick_size());
            if ($urandom_range(0, 1) == 1) write_reg(ptc_pkg::CFG_FRAME_COLS, pick_size());
            if ($urandom_range(0, 15) == 0) begin
                write_reg(CfgSpare, ptc_pkg::CfgDataW'($urandom_range(0, 2047)));
            end

            style = t_pixel_style'($urandom_range(0, 6));
            span  = frame_span(cfg_shadow.frame_rows, ptc_pkg::MaxRowsDef)
                  * frame_span(cfg_shadow.frame_cols, ptc_pkg::MaxColsDef);
            if (span > 60) begin
                count = $urandom_range(10, 60);
            end else begin
                count = span * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, span);
            end
            repeat (count) begin
                send_pixel(pick_pixel(style), Predicted, '0);
                random_sent++;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/ptc_pkg.sv
sv/ptc_pixel_eval.sv
sv/ptc_frame_stats.sv
sv/pixel_tissue_class_and_edge_stats.sv
sv/ptc_checker.sv
test/pixel_tissue_class_and_edge_stats_test.sv
